// ===== rtl/bed_pkg.sv =====
// Shared types and constants of the button event detector.
package bed_pkg;

  // Most events that one sample can give rise to.
  localparam int MaxEvents = 3;

  // Level of every button when not pressed, as it stands after reset.
  localparam logic [7:0] IdleMaskReset = 8'hFF;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_HOLD    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_DOUBLE  = 3'd4,
    EV_TRIPLE  = 3'd5
  } ev_code_e;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_HOLD      = 3'd1,
    CFG_REPEAT    = 3'd2,
    CFG_WINDOW    = 3'd3,
    CFG_IDLE_MASK = 3'd4,
    CFG_DEB_MASK  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] click_window_ticks;
    logic [7:0]  idle_level_mask;
    logic [7:0]  debounce_enable_mask;
  } cfg_t;

  // Per-button tracking state.
  typedef struct packed {
    logic        prev_level;
    logic [31:0] press_start;
    logic [31:0] repeat_mark;
    logic [31:0] last_press;
    logic [1:0]  click_count;
    logic        hold_seen;
    logic        had_repeat;
    logic        press_done;
    logic        last_valid;
  } btn_state_t;

  // One classified sample: up to three event codes in delivery order.
  typedef struct packed {
    logic [2:0]                  button_id;
    logic [1:0]                  n;
    logic [MaxEvents-1:0][2:0]   evs;
    logic [31:0]                 held;
    logic                        had_repeat;
  } rec_t;

endpackage

// ===== rtl/bed_cfg.sv =====
// Configuration register file of the button event detector.
module bed_cfg
  import bed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:  cfg_d.debounce_ticks       = cfg_data_i;
        CFG_HOLD:      cfg_d.hold_ticks           = cfg_data_i;
        CFG_REPEAT:    cfg_d.repeat_ticks         = cfg_data_i;
        CFG_WINDOW:    cfg_d.click_window_ticks   = cfg_data_i;
        CFG_IDLE_MASK: cfg_d.idle_level_mask      = cfg_data_i[7:0];
        CFG_DEB_MASK:  cfg_d.debounce_enable_mask = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks       <= 16'd20;
      cfg_q.hold_ticks           <= 16'd1000;
      cfg_q.repeat_ticks         <= 16'd200;
      cfg_q.click_window_ticks   <= 16'd300;
      cfg_q.idle_level_mask      <= IdleMaskReset;
      cfg_q.debounce_enable_mask <= 8'h00;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bed_front.sv =====
// Front end: takes samples, updates per-button state and classifies events.
module bed_front
  import bed_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  button_i,
  input  logic        level_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output rec_t        rec_o
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  btn_state_t btn_q [NUM_BUTTONS];
  btn_state_t s, ns;

  logic [IdxW-1:0] idx;
  logic            accept, in_range;
  logic            idle, deb, active, level_edge;
  logic [31:0]     el_ps, gap, rep_gap, held;
  logic            deb_ok, press, release_ev, dbl, trp, hold_ev, repeat_ev;
  logic [1:0]      c_next, cnt;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = 32'(button_i) < NUM_BUTTONS;
  assign idx        = IdxW'(button_i);

  always_comb begin
    s          = btn_q[idx];
    ns         = s;
    idle       = cfg_i.idle_level_mask[button_i];
    deb        = cfg_i.debounce_enable_mask[button_i];
    active     = level_i != idle;
    level_edge = level_i != s.prev_level;
    el_ps      = now_i - s.press_start;
    gap        = now_i - s.last_press;
    rep_gap    = now_i - s.repeat_mark;
    deb_ok     = el_ps > {16'd0, cfg_i.debounce_ticks};
    press      = 1'b0;
    release_ev = 1'b0;
    dbl        = 1'b0;
    trp        = 1'b0;
    hold_ev    = 1'b0;
    repeat_ev  = 1'b0;
    c_next     = s.click_count + 2'd1;

    if (level_edge) begin
      if (active) begin
        ns.press_start = now_i;
        ns.press_done  = 1'b0;
        if (!deb) begin
          press         = 1'b1;
          ns.press_done = 1'b1;
        end
      end else begin
        release_ev     = !deb || deb_ok;
        ns.press_start = '0;
        ns.repeat_mark = '0;
      end
    end else if (deb && active && !s.press_done && deb_ok) begin
      press         = 1'b1;
      ns.press_done = 1'b1;
    end
    ns.prev_level = level_i;

    // Multi-click counting against the previous reported press.
    if (press) begin
      if (!s.last_valid || gap >= {16'd0, cfg_i.click_window_ticks}) begin
        ns.click_count = 2'd0;
      end else begin
        if (c_next == 2'd1) begin
          dbl = 1'b1;
        end else if (c_next == 2'd2) begin
          trp    = 1'b1;
          c_next = 2'd0;
        end
        ns.click_count = c_next;
      end
      ns.last_press = now_i;
      ns.last_valid = 1'b1;
    end

    if (release_ev) begin
      ns.hold_seen  = 1'b0;
      ns.had_repeat = 1'b0;
      ns.press_done = 1'b0;
    end

    // A fresh press edge restarts the hold timer at zero.
    held = (level_edge && active) ? 32'd0 : el_ps;
    if (active && held >= {16'd0, cfg_i.hold_ticks}) begin
      if (s.hold_seen) begin
        if (rep_gap >= {16'd0, cfg_i.repeat_ticks}) begin
          repeat_ev      = 1'b1;
          ns.repeat_mark = now_i;
          ns.had_repeat  = 1'b1;
        end
      end else begin
        hold_ev        = 1'b1;
        ns.repeat_mark = now_i;
        ns.hold_seen   = 1'b1;
      end
    end

    // Pack the events in delivery order.
    rec_o            = '0;
    rec_o.button_id  = button_i;
    rec_o.held       = held;
    rec_o.had_repeat = s.had_repeat;
    cnt              = 2'd0;
    if (dbl) begin
      rec_o.evs[cnt] = EV_DOUBLE;
      cnt            = cnt + 2'd1;
    end
    if (trp) begin
      rec_o.evs[cnt] = EV_TRIPLE;
      cnt            = cnt + 2'd1;
    end
    if (press) begin
      rec_o.evs[cnt] = EV_PRESS;
      cnt            = cnt + 2'd1;
    end
    if (release_ev) begin
      rec_o.evs[cnt] = EV_RELEASE;
      cnt            = cnt + 2'd1;
    end
    if (hold_ev) begin
      rec_o.evs[cnt] = EV_HOLD;
      cnt            = cnt + 2'd1;
    end
    if (repeat_ev) begin
      rec_o.evs[cnt] = EV_REPEAT;
      cnt            = cnt + 2'd1;
    end
    rec_o.n = cnt;
  end

  assign push_o = accept && in_range && (cnt != 2'd0);

  // The previous level is the leading field, so it sits at the top of the reset word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_q[i] <= {(i < 8) && IdleMaskReset[3'(i)], {($bits(btn_state_t) - 1){1'b0}}};
      end
    end else if (accept && in_range) begin
      btn_q[idx] <= ns;
    end
  end

endmodule

// ===== rtl/bed_fifo.sv =====
// Short queue of classified samples between the front and back ends.
module bed_fifo
  import bed_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t wdata_i,
  input  logic pop_i,
  output rec_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rec_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bed_back.sv =====
// Back end: delivers the events of each queued sample, one per cycle while the output is not stalled.
module bed_back
  import bed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rec_t        rdata_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  button_id_o,
  output logic [2:0]  event_code_o,
  output logic [31:0] held_for_o,
  output logic        had_repeat_o,
  output logic        last_o
);

  rec_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] code;
  logic       fire, done;

  assign code         = cur_q.evs[idx_q];
  assign out_valid_o  = cur_valid_q;
  assign button_id_o  = cur_q.button_id;
  assign event_code_o = code;
  assign last_o       = idx_q == (cur_q.n - 2'd1);
  assign held_for_o   = (code == EV_HOLD || code == EV_REPEAT) ? cur_q.held : 32'd0;
  assign had_repeat_o = (code == EV_RELEASE) && cur_q.had_repeat;

  assign fire  = cur_valid_q && !out_stall_i;
  assign done  = !cur_valid_q || (fire && last_o);
  assign pop_o = done && !empty_i;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (done) begin
      cur_d       = rdata_i;
      cur_valid_d = !empty_i;
      idx_d       = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  // A sample with several events delivers them without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap inside the events of one sample");

  // Only samples that gave rise to at least one event reach the back end.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.n != 2'd0))
    else $error("empty record in the back end");

  // The event pointer stays within the events of the current sample.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx_q < cur_q.n))
    else $error("event pointer beyond the current sample");

endmodule

// ===== rtl/button_event_detector.sv =====
// Top level of the button event detector.
// Each request on the input channel is one sample of one button (index, raw level and tick
// time); the block keeps per-button state and reports press, release, hold, repeat, double
// click and triple click events on the output channel, one event per request, with last_o
// marking the final event of a sample. The front end classifies a sample in the cycle it is
// accepted and can take a new sample every cycle while the queue is not full; the back end
// delivers one event per cycle while the output is not stalled, so the events of a sample
// leave one after another and the sustained rate is one sample per cycle for single-event
// samples. A queue of QUEUE_DEPTH classified samples sits between the two ends, so the
// input is stalled only when that queue is full. Samples whose index is NUM_BUTTONS or
// more are accepted and dropped without any event. The six configuration
// registers (debounce, hold, repeat and click window times, idle level mask and debounce
// enable mask) are written through the configuration channel, which is always ready, and
// should only be written while no sample is in flight; writes to an index beyond the list
// are ignored.
module button_event_detector
  import bed_pkg::*;
#(
  parameter int NUM_BUTTONS = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  button_i,
  input  logic        level_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  button_id_o,
  output logic [2:0]  event_code_o,
  output logic [31:0] held_for_o,
  output logic        had_repeat_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg;
  rec_t wr_rec, rd_rec;
  logic push, pop, full, empty;

  bed_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Front end: state update and classification, one sample per cycle while the queue is not full.
  bed_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .button_i   (button_i),
    .level_i    (level_i),
    .now_i      (now_i),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (wr_rec)
  );

  bed_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_rec),
    .pop_i   (pop),
    .rdata_o (rd_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back end: serialises the events of each sample onto the output channel.
  bed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rdata_i      (rd_rec),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .button_id_o  (button_id_o),
    .event_code_o (event_code_o),
    .held_for_o   (held_for_o),
    .had_repeat_o (had_repeat_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/tb_button_event_detector.sv =====
// Self-checking testbench for the button event detector: directed and random samples.
`timescale 1ns / 100ps

module tb_button_event_detector;
  import bed_pkg::*;

  localparam int NumButtons = 8;
  // Cycles allowed for a sample that gives rise to no event to leave the pipeline.
  localparam int SettleCycles = 16;
  // Length of the long receiver hold-off that fills the internal queue.
  localparam int HoldOffCycles = 80;
  localparam int unsigned CycleLimit = 400000;
  localparam int SamplesPerPhase = 36;
  localparam int RandomPhases = 5;
  // Register indexes past the end of the register list; writes to them must be dropped.
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  // One expected event, in the order that the block must deliver it.
  typedef struct {
    logic [2:0]  button;
    ev_code_e    code;
    logic [31:0] held;
    logic        had_repeat;
    logic        is_last;
  } btn_event_t;

  // The scoreboard carries its own copy of the register settings and of the per-button
  // tracking state. Every accepted sample is run through it straight away, and the events
  // it predicts are queued until the output channel delivers them.
  class event_scoreboard;
    logic [15:0] debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] window_ticks;
    logic [7:0]  idle_mask;
    logic [7:0]  deb_mask;

    logic        level_q     [NumButtons];
    logic [31:0] press_t     [NumButtons];
    logic [31:0] repeat_t    [NumButtons];
    logic [31:0] click_t     [NumButtons];
    logic [1:0]  clicks      [NumButtons];
    logic        hold_seen   [NumButtons];
    logic        repeat_seen [NumButtons];
    logic        press_done  [NumButtons];
    logic        click_t_ok  [NumButtons];

    btn_event_t  expected_q[$];
    int unsigned errors;

    function new();
      debounce_ticks = 16'd20;
      hold_ticks     = 16'd1000;
      repeat_ticks   = 16'd200;
      window_ticks   = 16'd300;
      idle_mask      = IdleMaskReset;
      deb_mask       = 8'h00;
      errors         = 0;
      for (int i = 0; i < NumButtons; i++) begin
        level_q[i]     = IdleMaskReset[i];
        press_t[i]     = '0;
        repeat_t[i]    = '0;
        click_t[i]     = '0;
        clicks[i]      = '0;
        hold_seen[i]   = 1'b0;
        repeat_seen[i] = 1'b0;
        press_done[i]  = 1'b0;
        click_t_ok[i]  = 1'b0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_DEBOUNCE:  debounce_ticks = data;
        CFG_HOLD:      hold_ticks     = data;
        CFG_REPEAT:    repeat_ticks   = data;
        CFG_WINDOW:    window_ticks   = data;
        CFG_IDLE_MASK: idle_mask      = data[7:0];
        CFG_DEB_MASK:  deb_mask       = data[7:0];
        default: ;
      endcase
    endfunction

    function void queue_event(logic [2:0] b, ev_code_e code, logic [31:0] held, logic rep);
      btn_event_t ev;
      ev.button     = b;
      ev.code       = code;
      ev.held       = held;
      ev.had_repeat = rep;
      ev.is_last    = 1'b0;
      expected_q.push_back(ev);
    endfunction

    // Works out the events of one accepted sample and updates the tracking state.
    function void note_sample(logic [2:0] b, logic lvl, logic [31:0] t);
      logic        active;
      logic        pressed;
      logic        released;
      logic [31:0] since;
      logic [31:0] gap;
      logic [1:0]  c;
      int          first;
      first    = expected_q.size();
      active   = (lvl != idle_mask[b]);
      pressed  = 1'b0;
      released = 1'b0;

      if (lvl != level_q[b]) begin
        if (active) begin
          // Press edge: the press is reported at once unless the button is debounced.
          press_t[b]    = t;
          press_done[b] = 1'b0;
          if (!deb_mask[b]) begin
            pressed       = 1'b1;
            press_done[b] = 1'b1;
          end
        end else begin
          // Release edge: a debounced release only counts after a long enough press.
          since = t - press_t[b];
          if (!deb_mask[b] || since > debounce_ticks) released = 1'b1;
          press_t[b]  = '0;
          repeat_t[b] = '0;
        end
      end else if (deb_mask[b] && active && !press_done[b]) begin
        // A debounced press is reported once, on the first sample past the debounce time.
        since = t - press_t[b];
        if (since > debounce_ticks) begin
          pressed       = 1'b1;
          press_done[b] = 1'b1;
        end
      end
      level_q[b] = lvl;

      if (pressed) begin
        // The very first press of a button never counts towards a multi-click.
        gap = t - click_t[b];
        if (!click_t_ok[b] || gap >= window_ticks) begin
          clicks[b] = 2'd0;
        end else begin
          c = clicks[b] + 2'd1;
          if (c == 2'd1) begin
            queue_event(b, EV_DOUBLE, '0, 1'b0);
          end else if (c == 2'd2) begin
            queue_event(b, EV_TRIPLE, '0, 1'b0);
            c = 2'd0;
          end
          clicks[b] = c;
        end
        click_t[b]    = t;
        click_t_ok[b] = 1'b1;
        queue_event(b, EV_PRESS, '0, 1'b0);
      end

      if (released) begin
        queue_event(b, EV_RELEASE, '0, repeat_seen[b]);
        hold_seen[b]   = 1'b0;
        repeat_seen[b] = 1'b0;
        press_done[b]  = 1'b0;
      end

      // Hold fires once, then repeat fires each time the repeat interval has passed.
      since = t - press_t[b];
      if (active && since >= hold_ticks) begin
        if (hold_seen[b]) begin
          gap = t - repeat_t[b];
          if (gap >= repeat_ticks) begin
            repeat_t[b]    = t;
            repeat_seen[b] = 1'b1;
            queue_event(b, EV_REPEAT, since, 1'b0);
          end
        end else begin
          repeat_t[b]  = t;
          hold_seen[b] = 1'b1;
          queue_event(b, EV_HOLD, since, 1'b0);
        end
      end

      if (expected_q.size() > first) expected_q[expected_q.size() - 1].is_last = 1'b1;
    endfunction

    function void check_event(logic [2:0] b, logic [2:0] code, logic [31:0] held, logic rep,
                              logic is_last);
      btn_event_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: event with none expected: button %0d code %0d held %0d rep %0b last %0b",
                 $time, b, code, held, rep, is_last);
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.button || code !== want.code || held !== want.held ||
          rep !== want.had_repeat || is_last !== want.is_last) begin
        errors++;
        $display("%0t: event mismatch: expected button %0d code %0d held %0d rep %0b last %0b",
                 $time, want.button, want.code, want.held, want.had_repeat, want.is_last);
        $display("%0t:                 actual   button %0d code %0d held %0d rep %0b last %0b",
                 $time, b, code, held, rep, is_last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [2:0]  button_i     = '0;
  logic        level_i      = 1'b0;
  logic [31:0] now_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [2:0]  button_id_o;
  logic [2:0]  event_code_o;
  logic [31:0] held_for_o;
  logic        had_repeat_o;
  logic        last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i  = '0;
  logic [15:0] cfg_data_i   = '0;

  event_scoreboard sb;
  logic [31:0]     stamp;          // tick value of the next sample
  int unsigned     samples_sent;
  int unsigned     cycles = 0;
  logic            quiet = 1'b0;   // no idling on either side in the closing phase
  logic            rx_hold_req = 1'b0;

  button_event_detector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .button_i     (button_i),
    .level_i      (level_i),
    .now_i        (now_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .button_id_o  (button_id_o),
    .event_code_o (event_code_o),
    .held_for_o   (held_for_o),
    .had_repeat_o (had_repeat_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("button_event_detector verification failed");
      $finish;
    end
  end

  // Every event request taken by the testbench is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_event(button_id_o, event_code_o, held_for_o, had_repeat_o, last_o);
  end

  // Receiver: stall in random bursts, hold off for a long stretch on request, and stay
  // ready throughout the quiet phase. Each decision is driven once and held for its span.
  initial begin : receiver
    int unsigned span;
    logic        s;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        if (quiet) begin
          s    = 1'b0;
          span = 1;
        end else begin
          s    = ($urandom_range(0, 2) == 0);
          span = $urandom_range(1, 16);
        end
        out_stall_i <= s;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  // Advances the tick counter: mostly small steps, now and then a jump anywhere in the
  // 32-bit range so that wrap-around and every timestamp bit are exercised.
  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 15) == 0) stamp = stamp + $urandom();
    else stamp = stamp + $urandom_range(0, 90);
    return stamp;
  endfunction

  // Offers one sample request and holds it until it is taken. Valid stays high after
  // acceptance unless an idle burst follows, so back-to-back requests never toggle it.
  task automatic offer_sample(input logic [2:0] b, input logic lvl, input logic [31:0] t);
    int unsigned gap;
    in_valid_i <= 1'b1;
    button_i   <= b;
    level_i    <= lvl;
    now_i      <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(b, lvl, t);
    samples_sent++;
    gap = 0;
    if (!quiet && !rx_hold_req && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted event has been delivered, then lets
  // samples without events drain out of the pipeline as well.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Writes a full register setting, preceded by a write past the end of the list that
  // must have no effect. Valid is only lowered after the final write.
  task automatic apply_setting(input logic [15:0] deb, input logic [15:0] hold,
                               input logic [15:0] rep, input logic [15:0] win,
                               input logic [7:0] idle, input logic [7:0] debm);
    write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, 16'($urandom_range(0, 65535)));
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_REPEAT, rep);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_IDLE_MASK, {8'h00, idle});
    write_reg(CFG_DEB_MASK, {8'h00, debm});
    cfg_valid_i <= 1'b0;
  endtask

  // A well-formed press: an edge to the active level, a few samples held, then release.
  task automatic run_gesture();
    logic [2:0] b;
    logic       act;
    int         holds;
    b     = 3'($urandom_range(0, NumButtons - 1));
    act   = ~sb.idle_mask[b];
    holds = $urandom_range(0, 4);
    offer_sample(b, act, next_stamp());
    repeat (holds) offer_sample(b, act, next_stamp());
    offer_sample(b, ~act, next_stamp());
  endtask

  initial begin : stimulus
    int unsigned target;
    logic        held_off;
    sb = new();
    samples_sent = 0;
    held_off = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting, active level low on every button. Single, double and triple clicks,
    // hold and repeat with the repeat flag on release, and the click window boundary.
    offer_sample(3'd0, 1'b0, 32'd100);
    offer_sample(3'd0, 1'b1, 32'd150);
    offer_sample(3'd0, 1'b0, 32'd250);
    offer_sample(3'd0, 1'b1, 32'd260);
    offer_sample(3'd0, 1'b0, 32'd270);
    offer_sample(3'd0, 1'b0, 32'd1270);
    offer_sample(3'd0, 1'b0, 32'd1469);
    offer_sample(3'd0, 1'b0, 32'd1470);
    offer_sample(3'd0, 1'b1, 32'd1480);
    offer_sample(3'd0, 1'b0, 32'd1779);
    offer_sample(3'd0, 1'b1, 32'd1780);
    offer_sample(3'd0, 1'b0, 32'd2078);
    offer_sample(3'd0, 1'b1, 32'd2079);
    offer_sample(3'd0, 1'b0, 32'd2378);
    // Hold and repeat measured across the wrap of the tick counter.
    offer_sample(3'd7, 1'b0, 32'hFFFF_FF00);
    offer_sample(3'd7, 1'b0, 32'h0000_02E8);
    offer_sample(3'd7, 1'b0, 32'hFFFF_FFFF);
    offer_sample(3'd7, 1'b1, 32'h0000_0000);

    // Zero hold and repeat times: a press edge inside the window gives three events, and
    // a repeat can fire with no time passed at all.
    wait_idle();
    apply_setting(16'd0, 16'd0, 16'd0, 16'hFFFF, 8'hAA, 8'h00);
    offer_sample(3'd1, 1'b0, 32'd10);
    offer_sample(3'd1, 1'b1, 32'd20);
    offer_sample(3'd1, 1'b0, 32'd30);
    offer_sample(3'd1, 1'b0, 32'd30);

    // Debouncing on every button: the press only counts past the debounce time and is
    // reported once; a release after a short glitch is swallowed.
    wait_idle();
    apply_setting(16'd20, 16'hFFFF, 16'hFFFF, 16'd1, 8'h55, 8'hFF);
    offer_sample(3'd2, 1'b0, 32'd100);
    offer_sample(3'd2, 1'b0, 32'd120);
    offer_sample(3'd2, 1'b0, 32'd121);
    offer_sample(3'd2, 1'b1, 32'd141);
    offer_sample(3'd2, 1'b0, 32'd200);
    offer_sample(3'd2, 1'b1, 32'd210);

    // Random phases, each under its own setting: small random times, the largest times,
    // all times zero, and a closing phase with no idling on either side.
    stamp = $urandom();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      case (phase)
        2:       apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
        3:       apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 8'h00);
        default: apply_setting(16'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
                               16'($urandom_range(0, 120)), 16'($urandom_range(1, 400)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      quiet  = (phase == RandomPhases - 1);
      target = samples_sent + SamplesPerPhase;
      while (samples_sent < target) begin
        // Halfway through the second phase the receiver holds off while requests keep
        // coming, so the internal queue fills and the input is stalled.
        if (phase == 1 && !held_off && samples_sent + SamplesPerPhase / 2 >= target) begin
          held_off    = 1'b1;
          rx_hold_req = 1'b1;
          while (rx_hold_req) run_gesture();
        end
        if ($urandom_range(0, 4) == 0)
          offer_sample(3'($urandom_range(0, NumButtons - 1)), 1'($urandom_range(0, 1)),
                       next_stamp());
        else
          run_gesture();
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("button_event_detector verification clean");
    end else begin
      $display("button_event_detector verification failed");
    end
    $finish;
  end

endmodule
